// ===== rtl/gcc_pkg.sv =====
// Shared types, widths and helpers for the Gray-code correspondence decoder.
// No dependencies; used by gcc_regs and gray_code_correspondence.
package gcc_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned PLANE_W  = 4;
  localparam int unsigned CCOL_W   = 8;
  localparam int unsigned CROW_W   = 8;
  localparam int unsigned PCOL_W   = 7;
  localparam int unsigned PROW_W   = 7;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned THR_W    = 9;
  localparam int unsigned DIFF_W   = SAMPLE_W + 2;
  localparam int unsigned PT_W     = 8;

  // Gray fields: bit length of the projector width and height.
  localparam int unsigned GRAY_W = 8;
  localparam int unsigned CODE_W = 2 * GRAY_W;

  // Pixel word: {code, reverse valid, projector row, projector column}.
  localparam int unsigned REV_W  = 1 + PROW_W + PCOL_W;
  localparam int unsigned PIX_AW = CROW_W + CCOL_W;
  localparam int unsigned PIX_DW = CODE_W + REV_W;
  localparam int unsigned PIX_DEPTH = 1 << PIX_AW;

  // Code word: {valid, camera row, camera column}.
  localparam int unsigned CODE_DW = 1 + CROW_W + CCOL_W;
  localparam int unsigned CODE_DEPTH = 1 << CODE_W;

  // APB register map.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic REG_THRESHOLD = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_CAPTURE    = 3'd0,
    CMD_INVALIDATE = 3'd1,
    CMD_RECORD     = 3'd2,
    CMD_QUERY_PRJ  = 3'd3,
    CMD_QUERY_CAM  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_REV,
    ST_EMIT
  } state_e;

  function automatic logic [GRAY_W-1:0] gray_of(input logic [GRAY_W-1:0] v);
    gray_of = v ^ (v >> 1);
  endfunction

endpackage

// ===== rtl/gcc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Self-contained; no package dependency.
module gcc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gcc_regs.sv =====
// APB configuration register file: the signed binarisation threshold.
// Depends on gcc_pkg for widths and the register map.
module gcc_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gcc_pkg::PADDR_W-1:0]  paddr,
  input  logic [gcc_pkg::PDATA_W-1:0]  pwdata,
  output logic [gcc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic signed [gcc_pkg::THR_W-1:0] threshold_o
);

  logic [gcc_pkg::THR_W-1:0] thr_q;
  logic [gcc_pkg::THR_W-1:0] thr_d;
  logic                      sel_thr;

  assign pready  = 1'b1;
  assign sel_thr = (paddr[2] == gcc_pkg::REG_THRESHOLD);

  always_comb begin
    thr_d = thr_q;
    if (psel && penable && pwrite && pready && sel_thr) begin
      thr_d = pwdata[gcc_pkg::THR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else begin
      thr_q <= thr_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_thr) begin
      prdata = {{(gcc_pkg::PDATA_W-gcc_pkg::THR_W){thr_q[gcc_pkg::THR_W-1]}}, thr_q};
    end
  end

  assign threshold_o = $signed(thr_q);

endmodule

// ===== rtl/gray_code_correspondence.sv =====
// Channel  | Handshake                  | Beat contents
// ---------+----------------------------+--------------------------------------------
// in       | in_valid_i / in_ready_o    | command, plane, camera and projector pixel,
//          |                            | sample pair, mask bit, code index
// out      | out_valid_o / out_ready_i  | found, point column, point row
// cfg      | APB psel/penable/pwrite    | threshold at byte address 0
//
// Invalidate writes the code RAM directly; capture and record read and rewrite
// the pixel word, record also writing the code RAM for a nonzero code; camera
// query reads the pixel word; projector query reads the code word and, on a hit,
// rewrites the camera pixel word's reverse link. After reset a clearing pass
// writes every entry of both RAMs with in_ready_o low. A result waits in the
// output register; the next beat is taken meanwhile and only a second result stalls until out_ready_i.
// Depends on gcc_pkg, gcc_ram and gcc_regs.
module gray_code_correspondence (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gcc_pkg::PADDR_W-1:0]    paddr,
  input  logic [gcc_pkg::PDATA_W-1:0]    pwdata,
  output logic [gcc_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready,
  // command input
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [gcc_pkg::CMD_W-1:0]      command_i,
  input  logic [gcc_pkg::PLANE_W-1:0]    plane_i,
  input  logic [gcc_pkg::CCOL_W-1:0]     cam_col_i,
  input  logic [gcc_pkg::CROW_W-1:0]     cam_row_i,
  input  logic [gcc_pkg::PCOL_W-1:0]     prj_col_i,
  input  logic [gcc_pkg::PROW_W-1:0]     prj_row_i,
  input  logic [gcc_pkg::SAMPLE_W-1:0]   positive_sample_i,
  input  logic [gcc_pkg::SAMPLE_W-1:0]   negative_sample_i,
  input  logic                           mask_bit_i,
  input  logic [gcc_pkg::CODE_W-1:0]     code_index_i,
  // result output
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           found_o,
  output logic [gcc_pkg::PT_W-1:0]       point_col_o,
  output logic [gcc_pkg::PT_W-1:0]       point_row_o
);

  localparam int unsigned PIX_AW  = gcc_pkg::PIX_AW;
  localparam int unsigned PIX_DW  = gcc_pkg::PIX_DW;
  localparam int unsigned CODE_W  = gcc_pkg::CODE_W;
  localparam int unsigned CODE_DW = gcc_pkg::CODE_DW;
  localparam int unsigned REV_W   = gcc_pkg::REV_W;
  localparam int unsigned PT_W    = gcc_pkg::PT_W;
  localparam int unsigned GRAY_W  = gcc_pkg::GRAY_W;
  localparam int unsigned DIFF_W  = gcc_pkg::DIFF_W;

  gcc_pkg::state_e state_q, state_d;
  logic [PIX_AW-1:0] clr_q, clr_d;

  // latched beat
  gcc_pkg::cmd_e                 cmd_q;
  logic [gcc_pkg::PLANE_W-1:0]   plane_q;
  logic [CODE_W-1:0]             cbits_q;
  logic [gcc_pkg::CCOL_W-1:0]    ccol_q;
  logic [gcc_pkg::CROW_W-1:0]    crow_q;
  logic [gcc_pkg::PCOL_W-1:0]    pcol_q;
  logic [gcc_pkg::PROW_W-1:0]    prow_q;
  logic                          load_item;

  // pending result
  logic              res_found_q, res_found_d;
  logic [PT_W-1:0]   res_col_q, res_col_d;
  logic [PT_W-1:0]   res_row_q, res_row_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              out_found_q;
  logic [PT_W-1:0]   out_col_q;
  logic [PT_W-1:0]   out_row_q;
  logic              out_load;

  // RAM ports
  logic                 pix_we;
  logic [PIX_AW-1:0]    pix_waddr, pix_raddr;
  logic [PIX_DW-1:0]    pix_wdata, pix_rdata;
  logic                 code_we;
  logic [CODE_W-1:0]    code_waddr, code_raddr;
  logic [CODE_DW-1:0]   code_wdata, code_rdata;

  logic signed [gcc_pkg::THR_W-1:0] threshold;

  // capture binarisation
  logic signed [DIFF_W-1:0] diff;
  logic                     cap_bit;
  logic [CODE_W-1:0]        cap_bits;
  logic [GRAY_W-1:0]        gray_row, gray_col;

  // fields of the read words
  logic [CODE_W-1:0]  rd_code;
  logic [REV_W-1:0]   rd_rev;
  logic               rd_rev_valid;
  logic               cd_valid;
  logic [PT_W-1:0]    cd_row, cd_col;

  gcc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .threshold_o (threshold)
  );

  gcc_ram #(
    .WIDTH (PIX_DW),
    .DEPTH (gcc_pkg::PIX_DEPTH)
  ) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (pix_waddr),
    .wdata_i (pix_wdata),
    .raddr_i (pix_raddr),
    .rdata_o (pix_rdata)
  );

  gcc_ram #(
    .WIDTH (CODE_DW),
    .DEPTH (gcc_pkg::CODE_DEPTH)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (code_we),
    .waddr_i (code_waddr),
    .wdata_i (code_wdata),
    .raddr_i (code_raddr),
    .rdata_o (code_rdata)
  );

  assign diff = $signed({2'b00, positive_sample_i}) - $signed({2'b00, negative_sample_i});
  assign cap_bit = mask_bit_i && (diff >= DIFF_W'(threshold));
  // plane 0 is the top code bit
  assign cap_bits = {{(CODE_W-1){1'b0}}, cap_bit} << (gcc_pkg::PLANE_W'(CODE_W - 1) - plane_i);

  assign gray_row = gcc_pkg::gray_of(GRAY_W'(prj_row_i) + GRAY_W'(1));
  assign gray_col = gcc_pkg::gray_of(GRAY_W'(prj_col_i) + GRAY_W'(1));

  assign rd_code      = pix_rdata[PIX_DW-1:REV_W];
  assign rd_rev       = pix_rdata[REV_W-1:0];
  assign rd_rev_valid = rd_rev[REV_W-1];
  assign cd_valid     = code_rdata[CODE_DW-1];
  assign cd_row       = code_rdata[CODE_DW-2:gcc_pkg::CCOL_W];
  assign cd_col       = code_rdata[gcc_pkg::CCOL_W-1:0];

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    in_ready_o  = 1'b0;
    load_item   = 1'b0;
    out_load    = 1'b0;
    res_found_d = res_found_q;
    res_col_d   = res_col_q;
    res_row_d   = res_row_q;
    pix_we      = 1'b0;
    pix_waddr   = {crow_q, ccol_q};
    pix_wdata   = '0;
    pix_raddr   = {cam_row_i, cam_col_i};
    code_we     = 1'b0;
    code_waddr  = code_index_i;
    code_wdata  = '0;
    code_raddr  = {gray_row, gray_col};

    case (state_q)
      gcc_pkg::ST_CLEAR: begin
        pix_we     = 1'b1;
        pix_waddr  = clr_q;
        code_we    = 1'b1;
        code_waddr = CODE_W'(clr_q);
        clr_d      = clr_q + PIX_AW'(1);
        if (clr_q == '1) begin
          state_d = gcc_pkg::ST_IDLE;
        end
      end
      gcc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          load_item = 1'b1;
          case (command_i)
            gcc_pkg::CMD_INVALIDATE: begin
              code_we = 1'b1;
            end
            gcc_pkg::CMD_CAPTURE,
            gcc_pkg::CMD_RECORD,
            gcc_pkg::CMD_QUERY_PRJ,
            gcc_pkg::CMD_QUERY_CAM: begin
              state_d = gcc_pkg::ST_EXEC;
            end
            default: begin
              // unknown command: drop the beat
            end
          endcase
        end
      end
      gcc_pkg::ST_EXEC: begin
        state_d = gcc_pkg::ST_IDLE;
        case (cmd_q)
          gcc_pkg::CMD_CAPTURE: begin
            pix_we = 1'b1;
            if (plane_q == '0) begin
              pix_wdata = {cbits_q, rd_rev};
            end else begin
              pix_wdata = {rd_code | cbits_q, rd_rev};
            end
          end
          gcc_pkg::CMD_RECORD: begin
            // drop the reverse link, keep the code
            pix_we    = 1'b1;
            pix_wdata = {rd_code, {REV_W{1'b0}}};
            if (rd_code != '0) begin
              code_we    = 1'b1;
              code_waddr = rd_code;
              code_wdata = {1'b1, crow_q, ccol_q};
            end
          end
          gcc_pkg::CMD_QUERY_CAM: begin
            res_found_d = rd_rev_valid;
            res_col_d   = rd_rev_valid ? PT_W'(rd_rev[gcc_pkg::PCOL_W-1:0]) : '0;
            res_row_d   = rd_rev_valid ? PT_W'(rd_rev[REV_W-2:gcc_pkg::PCOL_W]) : '0;
            state_d     = gcc_pkg::ST_EMIT;
          end
          gcc_pkg::CMD_QUERY_PRJ: begin
            res_found_d = cd_valid;
            res_col_d   = cd_valid ? cd_col : '0;
            res_row_d   = cd_valid ? cd_row : '0;
            if (cd_valid) begin
              // fetch the camera pixel word to set its reverse link
              pix_raddr = {cd_row, cd_col};
              state_d   = gcc_pkg::ST_REV;
            end else begin
              state_d = gcc_pkg::ST_EMIT;
            end
          end
          default: begin
            state_d = gcc_pkg::ST_IDLE;
          end
        endcase
      end
      gcc_pkg::ST_REV: begin
        pix_we    = 1'b1;
        pix_waddr = {res_row_q, res_col_q};
        pix_wdata = {rd_code, 1'b1, prow_q, pcol_q};
        state_d   = gcc_pkg::ST_EMIT;
      end
      gcc_pkg::ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = gcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gcc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gcc_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_item) begin
      cmd_q   <= gcc_pkg::cmd_e'(command_i);
      plane_q <= plane_i;
      cbits_q <= cap_bits;
      ccol_q  <= cam_col_i;
      crow_q  <= cam_row_i;
      pcol_q  <= prj_col_i;
      prow_q  <= prj_row_i;
    end
    res_found_q <= res_found_d;
    res_col_q   <= res_col_d;
    res_row_q   <= res_row_d;
    if (out_load) begin
      out_found_q <= res_found_q;
      out_col_q   <= res_col_q;
      out_row_q   <= res_row_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign point_col_o = out_col_q;
  assign point_row_o = out_row_q;

endmodule
